### rtl/sme_pkg.sv
package sme_pkg;

	localparam int DATA_W    = 8;
	localparam int MOD_W     = 9;
	localparam int EXP_BITS  = 8;
	localparam int EXP_CNT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

	localparam logic [MOD_W-1:0]     MOD_MAX  = MOD_W'(256);
	localparam logic [MOD_W-1:0]     MOD_RST  = MOD_W'(256);
	localparam logic [EXP_CNT_W-1:0] EXP_LAST = EXP_CNT_W'(EXP_BITS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_RED,
		S_SQ_GO,
		S_SQ_WAIT,
		S_MUL_GO,
		S_MUL_WAIT
	} state_t;

	typedef struct packed {
		logic                    start;
		logic [DATA_W-1:0]       a;
		logic [DATA_W-1:0]       b;
	} mm_req_t;

	typedef struct packed {
		logic                    done;
		logic [DATA_W-1:0]       p;
	} mm_rsp_t;

endpackage

### rtl/sme_mulmod.sv
// Bit-serial modular multiply: a is scanned MSB first, one bit per cycle.
module sme_mulmod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sme_pkg::mm_req_t            req,
	input  logic [sme_pkg::MOD_W-1:0]   m,
	output sme_pkg::mm_rsp_t            rsp
);

	localparam int CNT_W = $clog2(sme_pkg::DATA_W);
	localparam int SUM_W = sme_pkg::MOD_W + 1;

	logic [sme_pkg::DATA_W-1:0] a_q;
	logic [sme_pkg::DATA_W-1:0] b_q;
	logic [sme_pkg::DATA_W-1:0] acc_q;
	logic [sme_pkg::MOD_W-1:0]  m_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [SUM_W-1:0] t0, t1, t2, m_ext;

	always_comb begin
		m_ext = SUM_W'(m_q);
		t0 = SUM_W'({acc_q, 1'b0}) + SUM_W'(b_q & {sme_pkg::DATA_W{a_q[sme_pkg::DATA_W-1]}});
		t1 = (t0 >= m_ext) ? (t0 - m_ext) : t0;
		t2 = (t1 >= m_ext) ? (t1 - m_ext) : t1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(sme_pkg::DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			m_q   <= m;
			acc_q <= '0;
		end else if (busy_q) begin
			a_q   <= a_q << 1;
			acc_q <= t2[sme_pkg::DATA_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = acc_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("mulmod started while busy");

	a_done_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (sme_pkg::MOD_W'(acc_q) < m_q) || (m_q == '0))
		else $error("mulmod product not reduced");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("mulmod done without a run");

endmodule

### rtl/small_modular_exponent_top.sv
// Modular exponentiation of a byte: result = base ^ exponent mod modulus.
// Modulus write channel: modulus with modulus_valid/modulus_ready; ready is
// always high, write only while busy is low. Zero gives result 0, values
// above 256 act as 256. Reset sets the modulus to 256.
// Command channel: an item is taken at an edge with start high and busy low.
// Result: result is shown for one cycle with done high; no backpressure.
// Work is left-to-right square-and-multiply over 8 exponent bits. Every
// modular multiply runs on one bit-serial unit, one multiplier bit per cycle.
// busy drops in the done cycle, so the next item can be taken then; no
// new item is taken while one is in progress.
module small_modular_exponent_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         modulus_valid,
	output logic                         modulus_ready,
	input  logic [sme_pkg::MOD_W-1:0]    modulus,
	input  logic                         start,
	output logic                         busy,
	input  logic [sme_pkg::DATA_W-1:0]   base,
	input  logic [sme_pkg::DATA_W-1:0]   exponent,
	output logic                         done,
	output logic [sme_pkg::DATA_W-1:0]   result
);

	sme_pkg::state_t state_q, state_d;

	logic [sme_pkg::MOD_W-1:0]     modulus_q;
	logic [sme_pkg::MOD_W-1:0]     m_q;
	logic                          zero_q;
	logic [sme_pkg::DATA_W-1:0]    base_q;
	logic [sme_pkg::DATA_W-1:0]    b_q;
	logic [sme_pkg::DATA_W-1:0]    r_q;
	logic [sme_pkg::EXP_BITS-1:0]  e_q;
	logic [sme_pkg::EXP_CNT_W-1:0] i_q;
	logic                          done_q;
	logic [sme_pkg::DATA_W-1:0]    result_q;

	sme_pkg::mm_req_t mm_req;
	sme_pkg::mm_rsp_t mm_rsp;

	logic accept, ld_b, ld_r, adv, fin, fin_zero;

	assign accept        = start && (state_q == sme_pkg::S_IDLE);
	assign modulus_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sme_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		mm_req   = '0;
		ld_b     = 1'b0;
		ld_r     = 1'b0;
		adv      = 1'b0;
		fin      = 1'b0;
		fin_zero = 1'b0;
		unique case (state_q)
			sme_pkg::S_IDLE: begin
				if (accept) begin
					state_d = sme_pkg::S_LOAD;
				end
			end
			sme_pkg::S_LOAD: begin
				if (zero_q) begin
					fin      = 1'b1;
					fin_zero = 1'b1;
					state_d  = sme_pkg::S_IDLE;
				end else begin
					mm_req.start = 1'b1;
					mm_req.a     = base_q;
					mm_req.b     = sme_pkg::DATA_W'(1);
					state_d      = sme_pkg::S_RED;
				end
			end
			sme_pkg::S_RED: begin
				if (mm_rsp.done) begin
					ld_b    = 1'b1;
					state_d = sme_pkg::S_SQ_GO;
				end
			end
			sme_pkg::S_SQ_GO: begin
				mm_req.start = 1'b1;
				mm_req.a     = r_q;
				mm_req.b     = r_q;
				state_d      = sme_pkg::S_SQ_WAIT;
			end
			sme_pkg::S_MUL_GO: begin
				mm_req.start = 1'b1;
				mm_req.a     = r_q;
				mm_req.b     = b_q;
				state_d      = sme_pkg::S_MUL_WAIT;
			end
			sme_pkg::S_SQ_WAIT, sme_pkg::S_MUL_WAIT: begin
				if (mm_rsp.done) begin
					ld_r = 1'b1;
					if (state_q == sme_pkg::S_SQ_WAIT && e_q[sme_pkg::EXP_BITS-1]) begin
						state_d = sme_pkg::S_MUL_GO;
					end else if (i_q == sme_pkg::EXP_LAST) begin
						fin     = 1'b1;
						state_d = sme_pkg::S_IDLE;
					end else begin
						adv     = 1'b1;
						state_d = sme_pkg::S_SQ_GO;
					end
				end
			end
			default: begin
				state_d = sme_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= sme_pkg::MOD_RST;
			done_q    <= 1'b0;
		end else begin
			if (modulus_valid && modulus_ready) begin
				modulus_q <= modulus;
			end
			done_q <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			zero_q <= (modulus_q == '0);
			m_q    <= (modulus_q > sme_pkg::MOD_MAX) ? sme_pkg::MOD_MAX : modulus_q;
			base_q <= base;
			e_q    <= sme_pkg::EXP_BITS'(exponent);
			i_q    <= '0;
		end
		if (ld_b) begin
			b_q <= mm_rsp.p;
			r_q <= (m_q == sme_pkg::MOD_W'(1)) ? '0 : sme_pkg::DATA_W'(1);
		end
		if (ld_r) begin
			r_q <= mm_rsp.p;
		end
		if (adv) begin
			e_q <= e_q << 1;
			i_q <= i_q + sme_pkg::EXP_CNT_W'(1);
		end
		if (fin) begin
			result_q <= fin_zero ? '0 : mm_rsp.p;
		end
	end

	sme_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.m      (m_q),
		.rsp    (mm_rsp)
	);

	assign busy   = (state_q != sme_pkg::S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("done outside the end of a run");

	a_mm_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		mm_rsp.done |-> (state_q == sme_pkg::S_RED) || (state_q == sme_pkg::S_SQ_WAIT)
			|| (state_q == sme_pkg::S_MUL_WAIT))
		else $error("multiply finished with no one waiting");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_q) |-> (result == '0))
		else $error("zero modulus gave nonzero result");

endmodule

### dv/small_modular_exponent_top_test.sv
`timescale 1ns / 100ps

module small_modular_exponent_top_test;

	class modpow_scoreboard;
		logic [sme_pkg::MOD_W-1:0]  modulus_now;
		logic [sme_pkg::DATA_W-1:0] pending_powers[$];
		int                         failures;

		function new();
			modulus_now = sme_pkg::MOD_RST;
			failures = 0;
		endfunction

		function logic [sme_pkg::DATA_W-1:0] power_mod(logic [sme_pkg::DATA_W-1:0] b,
				logic [sme_pkg::DATA_W-1:0] e);
			int unsigned m;
			int unsigned bm;
			int unsigned acc;
			int          i;
			if (modulus_now == '0)
				return '0;
			m = (modulus_now > sme_pkg::MOD_MAX) ? 32'd256 : 32'(modulus_now);
			bm = 32'(b) % m;
			acc = 1 % m;
			for (i = sme_pkg::EXP_BITS - 1; i >= 0; i--) begin
				acc = (acc * acc) % m;
				if (e[i])
					acc = (acc * bm) % m;
			end
			return acc[sme_pkg::DATA_W-1:0];
		endfunction

		function void note_item(logic [sme_pkg::DATA_W-1:0] b, logic [sme_pkg::DATA_W-1:0] e);
			pending_powers.push_back(power_mod(b, e));
		endfunction

		function void check_result(logic [sme_pkg::DATA_W-1:0] got);
			logic [sme_pkg::DATA_W-1:0] want;
			if (pending_powers.size() == 0) begin
				$error("result: expected none, got %0d", got);
				failures++;
				return;
			end
			want = pending_powers.pop_front();
			if (got !== want) begin
				$error("result: expected %0d, got %0d", want, got);
				failures++;
			end
		endfunction
	endclass

	localparam int DIR_N   = 17;
	localparam int PHASE_N = 63;

	logic                         clk;
	logic                         arst_n;
	logic                         modulus_valid;
	logic                         modulus_ready;
	logic [sme_pkg::MOD_W-1:0]    modulus;
	logic                         start;
	logic                         busy;
	logic [sme_pkg::DATA_W-1:0]   base;
	logic [sme_pkg::DATA_W-1:0]   exponent;
	logic                         done;
	logic [sme_pkg::DATA_W-1:0]   result;

	modpow_scoreboard sb;

	// {modulus, base, exponent}
	logic [24:0] directed_set [DIR_N];
	logic [8:0]  mod_plan [9];

	small_modular_exponent_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.modulus_valid (modulus_valid),
		.modulus_ready (modulus_ready),
		.modulus       (modulus),
		.start         (start),
		.busy          (busy),
		.base          (base),
		.exponent      (exponent),
		.done          (done),
		.result        (result)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	task automatic send_item(input logic [7:0] b, input logic [7:0] e, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		base <= b;
		exponent <= e;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_item(b, e);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending_powers.size() != 0);
	endtask

	task automatic write_modulus(input logic [8:0] v);
		modulus_valid <= 1'b1;
		modulus <= v;
		do @(posedge clk); while (modulus_ready !== 1'b1);
		modulus_valid <= 1'b0;
		sb.modulus_now = v;
	endtask

	task automatic run_phase(input logic [8:0] m);
		logic [7:0] b;
		logic [7:0] e;
		bit         burst;
		int         k;
		drain_results();
		write_modulus(m);
		burst = ($urandom_range(0, 2) == 0);
		for (k = 0; k < PHASE_N; k++) begin
			case ($urandom_range(0, 7))
				0:       b = 8'h00;
				1:       b = 8'hFF;
				2:       b = 8'h01;
				default: b = 8'($urandom_range(0, 255));
			endcase
			case ($urandom_range(0, 7))
				0:       e = 8'h00;
				1:       e = 8'hFF;
				2:       e = 8'($urandom_range(1, 3));
				3:       e = 8'h80 | 8'($urandom_range(0, 255));
				default: e = 8'($urandom_range(0, 255));
			endcase
			send_item(b, e, burst ? 0 : $urandom_range(0, 9));
			if ($urandom_range(0, 49) == 0)
				drain_results();
		end
	endtask

	initial begin
		int         k;
		logic [8:0] m;
		arst_n = 1'b0;
		start = 1'b0;
		base = '0;
		exponent = '0;
		modulus_valid = 1'b0;
		modulus = sme_pkg::MOD_RST;
		sb = new();
		directed_set = '{
			{9'd256, 8'd0,   8'd0},   {9'd256, 8'd255, 8'd255}, {9'd256, 8'd0,   8'd255},
			{9'd256, 8'd255, 8'd0},   {9'd256, 8'd1,   8'd255}, {9'd256, 8'd2,   8'd7},
			{9'd256, 8'd2,   8'd8},   {9'd256, 8'd16,  8'd2},   {9'd256, 8'd170, 8'd85},
			{9'd1,   8'd0,   8'd0},   {9'd1,   8'd255, 8'd255}, {9'd1,   8'd7,   8'd0},
			{9'd0,   8'd0,   8'd0},   {9'd0,   8'd255, 8'd255}, {9'd0,   8'd9,   8'd3},
			{9'd511, 8'd255, 8'd1},   {9'd511, 8'd3,   8'd200}
		};
		mod_plan = '{9'd143, 9'd2, 9'd255, 9'd221, 9'd0, 9'd257, 9'd3, 9'd187, 9'd256};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset modulus first, then new settings written only when drained
		for (k = 0; k < DIR_N; k++) begin
			m = directed_set[k][24:16];
			if (m != sb.modulus_now) begin
				drain_results();
				write_modulus(m);
			end
			send_item(directed_set[k][15:8], directed_set[k][7:0], $urandom_range(0, 9));
		end

		for (k = 0; k < 9; k++)
			run_phase(mod_plan[k]);
		run_phase(9'($urandom_range(4, 510)));

		drain_results();
		repeat (200) @(posedge clk);
		if (sb.failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
